FILE: hw/rtl/twr_pkg.sv
package twr_pkg;

    localparam int ISQRT_STAGES  = 6;   // three root digits per stage
    localparam int ISQRT_DIGITS  = 3;
    localparam int CORDIC_STAGES = 12;  // two micro-rotations per stage
    localparam int CORDIC_STEPS  = 24;
    localparam int CW            = 32;  // CORDIC datapath width, Q.26
    localparam int LAT           = 25;  // input beat to output register
    localparam int XY_TAPS       = 10;

    localparam logic [15:0] GAIN_RESET     = 16'd6144;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [31:0] INV_GAIN_Q32   = 32'd2608131496;

    localparam logic signed [16:0] OUT_MAX = 17'sd65535;
    localparam logic signed [16:0] OUT_MIN = -17'sd65536;

    typedef logic signed [CW-1:0] coord_t;

    // arctangent of 2^-i in turns, 2^32 per turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/twist_vertex_rotate_unit.sv
// Radial twist rotator: each input beat is a vertex (x, y) in signed Q2.14; the
// output beat is that vertex rotated about the origin by twist_gain * radius
// radians, in signed Q3.14. Fully pipelined, one vertex per clock, with stages
// square, 6 square-root stages, gain and phase multiplies, quadrant fold, 12
// CORDIC stages, inverse-gain multiply, round. The whole pipeline holds while
// the output beat waits. twist_gain (unsigned Q4.12, reset 1.5) is written via
// cfg_we/cfg_wdata by the user only while the stream is idle; not enforced here.
module twist_vertex_rotate_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_in[15:0], y_in[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // x_out[16:0], y_out[33:17], zero pad
);

    logic               en;
    logic [15:0]        gain_reg;
    logic [twr_pkg::LAT-1:0] vld_reg;

    logic [35:0]        sq_reg;
    logic [31:0]        xy_reg [0:twr_pkg::XY_TAPS-1];
    logic [17:0]        root;
    logic [33:0]        ang_reg;
    logic [46:0]        pl_reg, ph_reg;
    logic [31:0]        phase_reg;
    twr_pkg::coord_t    cx0_reg, cy0_reg;
    logic signed [31:0] z0_reg;
    twr_pkg::coord_t    xr, yr;
    logic signed [64:0] px_reg, py_reg;
    logic signed [16:0] xo_reg, yo_reg;

    assign en       = !vld_reg[twr_pkg::LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[twr_pkg::LAT-1];
    assign m_tdata  = {6'b0, yo_reg, xo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= twr_pkg::GAIN_RESET;
        end else if (cfg_we) begin
            gain_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[twr_pkg::LAT-2:0], s_tvalid};
        end
    end

    // radius squared, scaled to Q4.32 so the root lands in Q2.16
    always_ff @(posedge aclk) begin
        logic signed [31:0] xx, yy;
        if (en) begin
            xx = signed'(s_tdata[15:0]) * signed'(s_tdata[15:0]);
            yy = signed'(s_tdata[31:16]) * signed'(s_tdata[31:16]);
            sq_reg <= {32'(xx) + 32'(yy), 4'b0000};
            xy_reg[0] <= s_tdata;
            for (int i = 1; i < twr_pkg::XY_TAPS; i++) begin
                xy_reg[i] <= xy_reg[i-1];
            end
        end
    end

    twr_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (sq_reg),
        .root (root)
    );

    // angle, then phase in turns split into two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg   <= 34'(gain_reg) * 34'(root);
            pl_reg    <= 47'(ang_reg[16:0]) * 47'(twr_pkg::INV_TWO_PI_Q32);
            ph_reg    <= 47'(ang_reg[33:17]) * 47'(twr_pkg::INV_TWO_PI_Q32);
            phase_reg <= 32'(({17'b0, ph_reg} << 17) + {17'b0, pl_reg} >> 28);
        end
    end

    // quadrant fold: exact multiple of 90 degrees, residual in [-pi/4, pi/4)
    always_ff @(posedge aclk) begin
        logic [31:0]     p;
        twr_pkg::coord_t x, y;
        if (en) begin
            p = phase_reg + 32'h2000_0000;
            x = twr_pkg::coord_t'(signed'(xy_reg[twr_pkg::XY_TAPS-1][15:0])) <<< 12;
            y = twr_pkg::coord_t'(signed'(xy_reg[twr_pkg::XY_TAPS-1][31:16])) <<< 12;
            z0_reg <= signed'({2'b00, p[29:0]}) - 32'sh2000_0000;
            case (p[31:30])
                2'd1: begin cx0_reg <= -y; cy0_reg <= x;  end
                2'd2: begin cx0_reg <= -x; cy0_reg <= -y; end
                2'd3: begin cx0_reg <= y;  cy0_reg <= -x; end
                default: begin cx0_reg <= x; cy0_reg <= y; end
            endcase
        end
    end

    twr_cordic u_cordic (
        .aclk (aclk),
        .en   (en),
        .x0   (cx0_reg),
        .y0   (cy0_reg),
        .z0   (z0_reg),
        .xr   (xr),
        .yr   (yr)
    );

    function automatic logic signed [16:0] round_sat(input logic signed [64:0] v);
        logic signed [64:0] t;
        logic signed [20:0] r;
        t = v + (65'sd1 <<< 43);
        r = 21'(t >>> 44);
        if (r > 21'(twr_pkg::OUT_MAX)) return twr_pkg::OUT_MAX;
        if (r < 21'(twr_pkg::OUT_MIN)) return twr_pkg::OUT_MIN;
        return r[16:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= 65'(xr) * signed'({1'b0, twr_pkg::INV_GAIN_Q32});
            py_reg <= 65'(yr) * signed'({1'b0, twr_pkg::INV_GAIN_Q32});
            xo_reg <= round_sat(px_reg);
            yo_reg <= round_sat(py_reg);
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");
    a_rst: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (xo_reg < 17'sd50000 && xo_reg > -17'sd50000 &&
                      yo_reg < 17'sd50000 && yo_reg > -17'sd50000))
        else $error("rotated vertex outside reachable radius");
`endif

endmodule

FILE: hw/rtl/twr_isqrt.sv
module twr_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [35:0] rad,
    output logic [17:0] root
);

    logic [35:0] n_q    [0:twr_pkg::ISQRT_STAGES];
    logic [19:0] rem_q  [0:twr_pkg::ISQRT_STAGES];
    logic [17:0] root_q [0:twr_pkg::ISQRT_STAGES];

    assign n_q[0]    = rad;
    assign rem_q[0]  = '0;
    assign root_q[0] = '0;

    genvar g;
    generate
        for (g = 0; g < twr_pkg::ISQRT_STAGES; g++) begin : g_stage
            logic [35:0] n_next;
            logic [19:0] rem_next;
            logic [17:0] root_next;

            always_comb begin
                logic [21:0] rs;
                logic [21:0] trial;
                n_next    = n_q[g];
                rem_next  = rem_q[g];
                root_next = root_q[g];
                for (int d = 0; d < twr_pkg::ISQRT_DIGITS; d++) begin
                    rs    = {rem_next, n_next[35:34]};
                    trial = {2'b00, root_next, 2'b01};
                    n_next = {n_next[33:0], 2'b00};
                    if (rs >= trial) begin
                        rem_next  = 20'(rs - trial);
                        root_next = {root_next[16:0], 1'b1};
                    end else begin
                        rem_next  = rs[19:0];
                        root_next = {root_next[16:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    n_q[g+1]    <= n_next;
                    rem_q[g+1]  <= rem_next;
                    root_q[g+1] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_q[twr_pkg::ISQRT_STAGES];

endmodule

FILE: hw/rtl/twr_cordic.sv
module twr_cordic (
    input  logic                   aclk,
    input  logic                   en,
    input  twr_pkg::coord_t        x0,
    input  twr_pkg::coord_t        y0,
    input  logic signed [31:0]     z0,
    output twr_pkg::coord_t        xr,
    output twr_pkg::coord_t        yr
);

    twr_pkg::coord_t    x_q [0:twr_pkg::CORDIC_STAGES];
    twr_pkg::coord_t    y_q [0:twr_pkg::CORDIC_STAGES];
    logic signed [31:0] z_q [0:twr_pkg::CORDIC_STAGES];

    assign x_q[0] = x0;
    assign y_q[0] = y0;
    assign z_q[0] = z0;

    localparam int PER = twr_pkg::CORDIC_STEPS / twr_pkg::CORDIC_STAGES;

    genvar g;
    generate
        for (g = 0; g < twr_pkg::CORDIC_STAGES; g++) begin : g_stage
            twr_pkg::coord_t    x_next, y_next;
            logic signed [31:0] z_next;

            always_comb begin
                twr_pkg::coord_t dx, dy;
                x_next = x_q[g];
                y_next = y_q[g];
                z_next = z_q[g];
                for (int k = 0; k < PER; k++) begin
                    dx = y_next >>> (g * PER + k);
                    dy = x_next >>> (g * PER + k);
                    if (z_next >= 0) begin
                        x_next = x_next - dx;
                        y_next = y_next + dy;
                        z_next = z_next - signed'(twr_pkg::atan_turn(g * PER + k));
                    end else begin
                        x_next = x_next + dx;
                        y_next = y_next - dy;
                        z_next = z_next + signed'(twr_pkg::atan_turn(g * PER + k));
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_q[g+1] <= x_next;
                    y_q[g+1] <= y_next;
                    z_q[g+1] <= z_next;
                end
            end
        end
    endgenerate

    assign xr = x_q[twr_pkg::CORDIC_STAGES];
    assign yr = y_q[twr_pkg::CORDIC_STAGES];

endmodule
